// ----- src/reno_pkg.sv -----
// Shared types, codes and constants for the congestion window engine.
package reno_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned PKT_W       = 16;
	localparam int unsigned PROD_W      = WORD_W + PKT_W;
	localparam int unsigned SUM_W       = PROD_W + 1;
	localparam int unsigned CMD_W       = 3;
	localparam int unsigned ERR_W       = 2;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned PKT_LEN_DEFAULT = 1252;

	localparam logic [WORD_W-1:0] SS_THRESH_RST = 32'hFFFF_FFFF;
	localparam logic [PKT_W-1:0]  PKT_LEN_RST   = 16'd1252;
	localparam logic [PKT_W-1:0]  MIN_PKTS_RST  = 16'd2;
	localparam logic [PKT_W-1:0]  MAX_PKTS_RST  = 16'd2000;
	localparam logic [WORD_W-1:0] INIT_WIN_RST  = 32'd12520;
	localparam logic [WORD_W-1:0] WIN_LO_RST    = 32'd2504;
	localparam logic [WORD_W-1:0] WIN_HI_RST    = 32'd2504000;

	typedef enum logic [CMD_W-1:0] {
		CMD_SENT   = 3'd0,
		CMD_ACKED  = 3'd1,
		CMD_LOST   = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_SET    = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SS_THRESH = 3'd0,
		CFG_PKT_LEN   = 3'd1,
		CFG_MIN_PKTS  = 3'd2,
		CFG_MAX_PKTS  = 3'd3,
		CFG_INIT_WIN  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_SENT,
		OP_ACK,
		OP_LOSS,
		OP_LOSS_RESET,
		OP_REMOVE,
		OP_SET,
		OP_NOP
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE  = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_OVER  = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_DIV_START,
		BK_DIV_WAIT,
		BK_CLAMP,
		BK_RESULT
	} back_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [WORD_W-1:0] byte_count;
		logic              persistent_congestion;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] window_bytes;
		logic [WORD_W-1:0] inflight_bytes;
		logic [WORD_W-1:0] writable_bytes;
		logic              slow_start;
		logic [ERR_W-1:0]  error_code;
	} out_item_t;

	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] byte_count;
	} q_entry_t;

	typedef struct packed {
		logic [WORD_W-1:0] ss_thresh;
		logic [WORD_W-1:0] window_lo;
		logic [WORD_W-1:0] window_hi;
	} cfg_t;

endpackage

// ----- src/reno_window_update_top.sv -----
// Top level of the per-connection congestion window engine.
//
// This block keeps one connection's congestion window and bytes in flight and
// handles one event per input transaction: packet sent, ack, loss, removal of
// bytes from flight, or a direct window load. Each event returns exactly one
// output transaction carrying the new window, the bytes in flight, the writable
// bytes and the slow start flag, plus an error code when a sum or difference
// saturated. Events enter a two-entry queue, so up to two can be taken while
// the execution side is busy or the output is stalled. The execution side runs
// one event at a time: sends, removals, losses, window loads and unknown
// commands pass through execute and result, an ack in slow start or on a zero
// window adds a clamp step, and any other ack in congestion avoidance first runs
// the 48-step radix-2 divider that divides the default packet length times the
// acked bytes by the current window. Window bounds are min and max packets
// times the packet length, recomputed in registers from the configuration
// registers after a write. Writes to the initial window register are accepted
// but have no effect: reset always loads a window of 12520 bytes.
module reno_window_update_top #(
	parameter int unsigned DEFAULT_PACKET_LEN = reno_pkg::PKT_LEN_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [reno_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [reno_pkg::WORD_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  reno_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output reno_pkg::out_item_t            out_item
);
	import reno_pkg::*;

	logic [WORD_W-1:0] ss_thresh_q;
	logic [PKT_W-1:0]  pkt_len_q;
	logic [PKT_W-1:0]  min_pkts_q;
	logic [PKT_W-1:0]  max_pkts_q;
	logic [WORD_W-1:0] win_lo_q;
	logic [WORD_W-1:0] win_hi_q;
	cfg_t              cfg;

	logic              q_valid;
	q_entry_t          q_head;
	logic              q_pop;

	// Configuration registers. The initial window index is decoded but not
	// stored, since the block's own reset always restores the default window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_thresh_q <= SS_THRESH_RST;
			pkt_len_q   <= PKT_LEN_RST;
			min_pkts_q  <= MIN_PKTS_RST;
			max_pkts_q  <= MAX_PKTS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SS_THRESH: ss_thresh_q <= cfg_data;
				CFG_PKT_LEN:   pkt_len_q   <= cfg_data[PKT_W-1:0];
				CFG_MIN_PKTS:  min_pkts_q  <= cfg_data[PKT_W-1:0];
				CFG_MAX_PKTS:  max_pkts_q  <= cfg_data[PKT_W-1:0];
				CFG_INIT_WIN: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Window bounds in bytes; a 16 by 16 product always fits in 32 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_lo_q <= WIN_LO_RST;
			win_hi_q <= WIN_HI_RST;
		end else begin
			win_lo_q <= {{PKT_W{1'b0}}, min_pkts_q} * {{PKT_W{1'b0}}, pkt_len_q};
			win_hi_q <= {{PKT_W{1'b0}}, max_pkts_q} * {{PKT_W{1'b0}}, pkt_len_q};
		end
	end

	always_comb begin
		cfg.ss_thresh = ss_thresh_q;
		cfg.window_lo = win_lo_q;
		cfg.window_hi = win_hi_q;
	end

	reno_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	reno_back #(
		.DEFAULT_PACKET_LEN (DEFAULT_PACKET_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- src/reno_div.sv -----
// Radix-2 restoring divider for the congestion avoidance growth term.
module reno_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [reno_pkg::PROD_W-1:0]  dividend,
	input  logic [reno_pkg::WORD_W-1:0]  divisor,
	output logic                         done,
	output logic [reno_pkg::PROD_W-1:0]  quotient
);
	import reno_pkg::*;

	localparam int unsigned CNT_W = $clog2(PROD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] dvs_q;
	logic [PROD_W-1:0] quo_q;

	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;
	logic              ge;

	// One quotient bit per cycle: shift the next dividend bit into the remainder.
	always_comb begin
		shifted = {rem_q, quo_q[PROD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
`endif

endmodule

// ----- src/reno_back.sv -----
// Execution side: holds window and in-flight state, runs each queued event.
module reno_back #(
	parameter int unsigned DEFAULT_PACKET_LEN = reno_pkg::PKT_LEN_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  reno_pkg::cfg_t      cfg,
	input  logic                q_valid,
	input  reno_pkg::q_entry_t  q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output reno_pkg::out_item_t out_item
);
	import reno_pkg::*;

	localparam logic [PKT_W-1:0] PKT_MULT = PKT_W'(DEFAULT_PACKET_LEN);

	back_state_t       state_q, state_d;
	op_t               op_q;
	logic [WORD_W-1:0] bytes_q;
	logic [WORD_W-1:0] window_q;
	logic [WORD_W-1:0] inflight_q;
	err_t              err_q;
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  sum_q;
	out_item_t         out_item_q;
	logic              out_valid_q;

	logic              out_load;
	logic              div_start;
	logic              div_done;
	logic [PROD_W-1:0] div_quot;

	logic [WORD_W:0]   add_sum;
	logic              sub_under;
	logic [WORD_W-1:0] sub_diff;
	logic              ss_now;
	logic              sum_over;
	logic [WORD_W-1:0] clamp_w;
	logic [WORD_W-1:0] writable;

	reno_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (window_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		add_sum   = {1'b0, inflight_q} + {1'b0, bytes_q};
		sub_under = bytes_q > inflight_q;
		sub_diff  = inflight_q - bytes_q;
		ss_now    = window_q < cfg.ss_thresh;
		sum_over  = |sum_q[SUM_W-1:WORD_W];
		// Saturate, then apply the lower bound and the upper bound; the upper one wins.
		clamp_w   = sum_over ? '1 : sum_q[WORD_W-1:0];
		if (clamp_w < cfg.window_lo) begin
			clamp_w = cfg.window_lo;
		end
		if (clamp_w > cfg.window_hi) begin
			clamp_w = cfg.window_hi;
		end
		writable  = (inflight_q > window_q) ? '0 : window_q - inflight_q;
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (op_q == OP_ACK) begin
					state_d = (ss_now || window_q == '0) ? BK_CLAMP : BK_DIV_START;
				end else begin
					state_d = BK_RESULT;
				end
			end
			BK_DIV_START: begin
				div_start = 1'b1;
				state_d   = BK_DIV_WAIT;
			end
			BK_DIV_WAIT: begin
				if (div_done) begin
					state_d = BK_CLAMP;
				end
			end
			BK_CLAMP: begin
				state_d = BK_RESULT;
			end
			BK_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			window_q    <= INIT_WIN_RST;
			inflight_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == BK_EXEC) begin
				unique case (op_q)
					OP_SENT: begin
						inflight_q <= add_sum[WORD_W] ? '1 : add_sum[WORD_W-1:0];
					end
					OP_ACK, OP_LOSS, OP_REMOVE: begin
						inflight_q <= sub_under ? '0 : sub_diff;
					end
					OP_LOSS_RESET: begin
						inflight_q <= sub_under ? '0 : sub_diff;
						window_q   <= cfg.window_lo;
					end
					OP_SET: begin
						window_q <= bytes_q;
					end
					default: begin
					end
				endcase
			end else if (state_q == BK_CLAMP) begin
				window_q <= clamp_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q    <= q_head.op;
			bytes_q <= q_head.byte_count;
		end
		if (state_q == BK_EXEC) begin
			unique case (op_q)
				OP_SENT: begin
					err_q <= add_sum[WORD_W] ? ERR_OVER : ERR_NONE;
				end
				OP_ACK, OP_LOSS, OP_LOSS_RESET, OP_REMOVE: begin
					err_q <= sub_under ? ERR_UNDER : ERR_NONE;
				end
				default: begin
					err_q <= ERR_NONE;
				end
			endcase
			if (op_q == OP_ACK) begin
				// Slow start adds the acked bytes; a zero window grows by nothing.
				sum_q  <= ss_now ? {{PKT_W{1'b0}}, {1'b0, window_q} + {1'b0, bytes_q}}
					: {{(SUM_W-WORD_W){1'b0}}, window_q};
				prod_q <= {{WORD_W{1'b0}}, PKT_MULT} * {{PKT_W{1'b0}}, bytes_q};
			end
		end
		if (state_q == BK_DIV_WAIT && div_done) begin
			sum_q <= {{(SUM_W-WORD_W){1'b0}}, window_q} + {1'b0, div_quot};
		end
		if (state_q == BK_CLAMP && sum_over) begin
			err_q <= ERR_OVER;
		end
		if (out_load) begin
			out_item_q.window_bytes   <= window_q;
			out_item_q.inflight_bytes <= inflight_q;
			out_item_q.writable_bytes <= writable;
			out_item_q.slow_start     <= ss_now;
			out_item_q.error_code     <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == BK_DIV_WAIT)
		else $error("divider finished outside the wait state");
	a_clamp_hi: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CLAMP |=> window_q <= $past(cfg.window_hi))
		else $error("window above upper bound after clamp");
`endif

endmodule

// ----- src/reno_front.sv -----
// Intake side: classifies incoming events and queues them for execution.
module reno_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  reno_pkg::in_item_t  in_item,
	output logic                q_valid,
	output reno_pkg::q_entry_t  q_head,
	input  logic                q_pop
);
	import reno_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	q_entry_t         entry;
	logic             push;

	always_comb begin
		entry.byte_count = in_item.byte_count;
		unique case (in_item.command)
			CMD_SENT:   entry.op = OP_SENT;
			CMD_ACKED:  entry.op = OP_ACK;
			CMD_LOST:   entry.op = in_item.persistent_congestion ? OP_LOSS_RESET : OP_LOSS;
			CMD_REMOVE: entry.op = OP_REMOVE;
			CMD_SET:    entry.op = OP_SET;
			default:    entry.op = OP_NOP;
		endcase
	end

	assign in_stall = count_q == CNT_W'(QUEUE_DEPTH);
	assign push     = in_valid && !in_stall;
	assign q_valid  = count_q != '0;
	assign q_head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != '0)
		else $error("queue popped while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");
`endif

endmodule

// ----- dv/reno_window_update_top_tb.sv -----
// Self-checking testbench for the congestion window engine top level.
module reno_window_update_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import reno_pkg::*;

	// Words of the testbench.
	localparam logic [WORD_W-1:0] WORD_MAX = '1;
	localparam logic [WORD_W-1:0] WORD_MSB = 32'h8000_0000;

	// Command codes with no meaning to the block. It must answer them with the
	// current state and no error.
	localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

	// Once every owed result is back the block is idle; the settle cycles
	// follow before the next phase.
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 64;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_EVENTS  = 190;
	localparam int MAX_REPORTS   = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;

	reno_window_update_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// Shadow of the configuration registers, loaded with their reset values.
	logic [WORD_W-1:0] thresh_cfg   = SS_THRESH_RST;
	logic [PKT_W-1:0]  pkt_len_cfg  = PKT_LEN_RST;
	logic [PKT_W-1:0]  min_pkts_cfg = MIN_PKTS_RST;
	logic [PKT_W-1:0]  max_pkts_cfg = MAX_PKTS_RST;

	// Predicted connection state.
	logic [WORD_W-1:0] win_q    = INIT_WIN_RST;
	logic [WORD_W-1:0] flight_q = '0;

	// Window results still owed by the block, oldest first.
	out_item_t window_results_q[$];

	int fail_count   = 0;
	int report_count = 0;
	int n_accepted   = 0;
	int n_checked    = 0;
	int n_settings   = 1;

	// Idling controls for the two sides, and the long receiver hold-off. Each
	// toggle of the request starts one hold-off.
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	logic hold_req = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t mk(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] bytes,
			input logic persist);
		in_item_t ev;
		ev.command = cmd;
		ev.byte_count = bytes;
		ev.persistent_congestion = persist;
		return ev;
	endfunction

	// Saturating removal of bytes from flight, shared by ack, loss and remove.
	function automatic logic [WORD_W-1:0] drain_flight(input logic [WORD_W-1:0] bytes,
			inout err_t err);
		if (bytes > flight_q) begin
			err = ERR_UNDER;
			return '0;
		end
		return flight_q - bytes;
	endfunction

	// Applies one event to the predicted state and returns the result the block
	// must report for it.
	function automatic out_item_t predict_window(input in_item_t ev);
		logic [63:0]       grow;
		logic [63:0]       sum;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		err_t              err;
		out_item_t         res;
		err = ERR_NONE;
		lo = 32'(min_pkts_cfg) * 32'(pkt_len_cfg);
		hi = 32'(max_pkts_cfg) * 32'(pkt_len_cfg);
		case (ev.command)
			CMD_SENT: begin
				sum = 64'(flight_q) + 64'(ev.byte_count);
				if (sum > 64'(WORD_MAX)) begin
					err = ERR_OVER;
					flight_q = WORD_MAX;
				end else begin
					flight_q = sum[WORD_W-1:0];
				end
			end
			CMD_ACKED: begin
				flight_q = drain_flight(ev.byte_count, err);
				// Slow start grows by the acked bytes; congestion avoidance by the default
				// packet length times the acked bytes over the window, nothing on a zero window.
				if (win_q < thresh_cfg)
					grow = 64'(ev.byte_count);
				else if (win_q == '0)
					grow = '0;
				else
					grow = (64'(PKT_LEN_DEFAULT) * 64'(ev.byte_count)) / 64'(win_q);
				sum = 64'(win_q) + grow;
				if (sum > 64'(WORD_MAX)) begin
					err = ERR_OVER;
					win_q = WORD_MAX;
				end else begin
					win_q = sum[WORD_W-1:0];
				end
				// The upper bound is applied last, so it wins when the bounds cross.
				if (win_q < lo)
					win_q = lo;
				if (win_q > hi)
					win_q = hi;
			end
			CMD_LOST: begin
				flight_q = drain_flight(ev.byte_count, err);
				if (ev.persistent_congestion)
					win_q = lo;
			end
			CMD_REMOVE: begin
				flight_q = drain_flight(ev.byte_count, err);
			end
			CMD_SET: begin
				win_q = ev.byte_count;
			end
			default: begin
			end
		endcase
		res.window_bytes = win_q;
		res.inflight_bytes = flight_q;
		res.writable_bytes = (flight_q > win_q) ? '0 : win_q - flight_q;
		res.slow_start = (win_q < thresh_cfg);
		res.error_code = err;
		return res;
	endfunction

	// Every accepted input transaction is predicted at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			window_results_q.push_back(predict_window(in_item));
			n_accepted++;
		end
	end

	// Every accepted output transaction is compared with the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (window_results_q.size() == 0) begin
				fail_count++;
				if (report_count < MAX_REPORTS)
					$display("ERROR: unexpected result win=%h flight=%h", out_item.window_bytes,
						out_item.inflight_bytes);
				report_count++;
			end else begin
				want = window_results_q.pop_front();
				n_checked++;
				if (out_item !== want) begin
					fail_count++;
					if (report_count < MAX_REPORTS) begin
						$display("ERROR: result %0d expected win=%h flight=%h wr=%h ss=%b err=%0d",
							n_checked, want.window_bytes, want.inflight_bytes,
							want.writable_bytes, want.slow_start, want.error_code);
						$display("       got      win=%h flight=%h wr=%h ss=%b err=%0d",
							out_item.window_bytes, out_item.inflight_bytes,
							out_item.writable_bytes, out_item.slow_start, out_item.error_code);
					end
					report_count++;
				end
			end
		end
	end

	// Receiver. A requested hold-off stalls the output for a long counted stretch;
	// otherwise stall runs of random length come and go while idling is enabled.
	always @(posedge clk) begin
		int hold_left;
		int stall_left;
		logic hold_seen;
		if (hold_req !== hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!rx_idle_en) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Offers one transaction and returns at the edge that accepts it. Valid stays
	// high so that a transaction sent next without a gap follows back to back;
	// anything that lets time pass afterwards lowers it first.
	task automatic send_event(input in_item_t ev);
		int gap;
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= ev;
		do @(posedge clk); while (in_stall);
	endtask

	// Stops offering and waits for every owed result, then lets the block settle.
	// The first edge makes sure the last accepted transaction has been predicted.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (window_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [WORD_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SS_THRESH: thresh_cfg = val;
			CFG_PKT_LEN:   pkt_len_cfg = val[PKT_W-1:0];
			CFG_MIN_PKTS:  min_pkts_cfg = val[PKT_W-1:0];
			CFG_MAX_PKTS:  max_pkts_cfg = val[PKT_W-1:0];
			// The initial window only matters at reset, and reset happens once,
			// so writes to it must not move the window that the block reports.
			default: begin
			end
		endcase
	endtask

	// Loads a full register setting while the block is idle. The window bounds
	// are rebuilt in registers after a write, so the task waits before traffic.
	task automatic set_config(input logic [WORD_W-1:0] thresh, input logic [PKT_W-1:0] pkt,
			input logic [PKT_W-1:0] min_pkts, input logic [PKT_W-1:0] max_pkts);
		wait_idle();
		cfg_write(CFG_SS_THRESH, thresh);
		cfg_write(CFG_PKT_LEN, 32'(pkt));
		cfg_write(CFG_MIN_PKTS, 32'(min_pkts));
		cfg_write(CFG_MAX_PKTS, 32'(max_pkts));
		cfg_write(CFG_INIT_WIN, $urandom_range(1, 32'hFFFF_FFFF));
		repeat (4) @(posedge clk);
		n_settings++;
	endtask

	function automatic logic [WORD_W-1:0] rand_bytes();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom();
		if (r < 6) begin
			case ($urandom_range(0, 4))
				0: return '0;
				1: return 32'd1;
				2: return WORD_MAX;
				3: return WORD_MAX - 1;
				default: return WORD_MSB;
			endcase
		end
		return $urandom_range(0, 4 * 32'(pkt_len_cfg));
	endfunction

	// Unstructured transaction: any command, including the unused codes.
	function automatic in_item_t noise_event();
		logic [CMD_W-1:0] cmd;
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			cmd = CMD_SENT;
		else if (r < 45)
			cmd = CMD_ACKED;
		else if (r < 60)
			cmd = CMD_LOST;
		else if (r < 75)
			cmd = CMD_REMOVE;
		else if (r < 90)
			cmd = CMD_SET;
		else
			cmd = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
		return mk(cmd, rand_bytes(), 1'($urandom_range(0, 1)));
	endfunction

	// What comes back for one packet of a flight: mostly an ack, sometimes a
	// loss, a removal, or a partial ack.
	function automatic in_item_t flight_reply();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return mk(CMD_ACKED, 32'(pkt_len_cfg), 1'($urandom_range(0, 1)));
		if (r < 87)
			return mk(CMD_LOST, 32'(pkt_len_cfg), ($urandom_range(0, 4) == 0));
		if (r < 94)
			return mk(CMD_REMOVE, 32'(pkt_len_cfg), 1'b0);
		return mk(CMD_ACKED, $urandom_range(0, 32'(pkt_len_cfg)), 1'b0);
	endfunction

	// Mostly flights of sends answered by acks and losses, with noise between.
	task automatic run_traffic(input int n_events);
		int count;
		int k;
		count = 0;
		while (count < n_events) begin
			if ($urandom_range(0, 9) < 8) begin
				k = $urandom_range(1, 6);
				repeat (k) send_event(mk(CMD_SENT, 32'(pkt_len_cfg), 1'($urandom_range(0, 1))));
				repeat (k) send_event(flight_reply());
				count += 2 * k;
			end else begin
				send_event(noise_event());
				count++;
			end
		end
	endtask

	// Reset settings: saturation both ways, both errors in one ack, a loss with
	// and without persistent congestion, unclamped window loads including zero
	// and all ones, unused command codes, and in flight above the window.
	task automatic test_directed_defaults();
		send_event(mk(CMD_SENT, '0, 1'b0));
		send_event(mk(CMD_SENT, WORD_MAX, 1'b0));
		send_event(mk(CMD_SENT, 32'd1, 1'b0));
		send_event(mk(CMD_REMOVE, WORD_MAX, 1'b1));
		send_event(mk(CMD_REMOVE, 32'd1, 1'b0));
		send_event(mk(CMD_SENT, 32'd5000, 1'b1));
		send_event(mk(CMD_ACKED, 32'd1000, 1'b1));
		send_event(mk(CMD_LOST, 32'd1000, 1'b0));
		send_event(mk(CMD_LOST, '0, 1'b1));
		send_event(mk(CMD_ACKED, WORD_MAX, 1'b0));
		send_event(mk(CMD_SET, WORD_MAX, 1'b0));
		send_event(mk(CMD_ACKED, 32'd2000, 1'b0));
		send_event(mk(CMD_SET, '0, 1'b0));
		send_event(mk(CMD_SENT, 32'd300, 1'b0));
		send_event(mk(CMD_ACKED, '0, 1'b0));
		send_event(mk(CMD_BAD_LO, WORD_MAX, 1'b1));
		send_event(mk(CMD_BAD_LO + 3'd1, '0, 1'b0));
		send_event(mk(CMD_BAD_HI, WORD_MSB, 1'b1));
		send_event(mk(CMD_SET, 32'd100, 1'b0));
		send_event(mk(CMD_SENT, 32'd200, 1'b0));
		send_event(mk(CMD_REMOVE, WORD_MSB, 1'b0));
		send_event(mk(CMD_SET, 32'hFFFF_0000, 1'b0));
		send_event(mk(CMD_ACKED, 32'h0010_0000, 1'b0));
		wait_idle();
	endtask

	// Register extremes: a zero threshold with a zero window, the largest
	// bounds, crossed bounds, and the smallest packet length.
	task automatic test_config_extremes();
		set_config('0, PKT_LEN_RST, MIN_PKTS_RST, MAX_PKTS_RST);
		send_event(mk(CMD_SET, '0, 1'b0));
		send_event(mk(CMD_ACKED, 32'd5000, 1'b0));
		send_event(mk(CMD_SET, 32'd1, 1'b0));
		send_event(mk(CMD_ACKED, WORD_MAX, 1'b0));
		send_event(mk(CMD_ACKED, 32'd1, 1'b0));
		set_config(WORD_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_event(mk(CMD_ACKED, '0, 1'b0));
		send_event(mk(CMD_ACKED, WORD_MAX, 1'b0));
		send_event(mk(CMD_LOST, '0, 1'b1));
		set_config(32'd70000, 16'd1, 16'hFFFF, 16'd1);
		send_event(mk(CMD_ACKED, 32'd10, 1'b0));
		send_event(mk(CMD_LOST, '0, 1'b1));
		send_event(mk(CMD_ACKED, '0, 1'b0));
		set_config(WORD_MAX - 1, 16'd1, 16'd1, 16'hFFFF);
		send_event(mk(CMD_SET, WORD_MAX - 1, 1'b0));
		send_event(mk(CMD_ACKED, 32'd1, 1'b0));
		send_event(mk(CMD_ACKED, 32'd1, 1'b0));
		wait_idle();
		cfg_write(CFG_INIT_WIN, 32'd1);
		cfg_write(CFG_INIT_WIN, WORD_MAX);
		repeat (4) @(posedge clk);
		send_event(mk(CMD_BAD_HI, '0, 1'b0));
		wait_idle();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// back to back, so the queue fills and the input stalls.
	task automatic test_backpressure();
		set_config(32'd20000, PKT_LEN_RST, MIN_PKTS_RST, MAX_PKTS_RST);
		tx_idle_en = 1'b0;
		hold_req <= ~hold_req;
		repeat (8) begin
			send_event(mk(CMD_SENT, 32'(pkt_len_cfg), 1'b0));
			send_event(mk(CMD_ACKED, 32'(pkt_len_cfg), 1'b0));
		end
		wait_idle();
		tx_idle_en = 1'b1;
	endtask

	// The sender stops after each burst until every result is back.
	task automatic test_sender_pause();
		repeat (3) begin
			run_traffic(8);
			wait_idle();
		end
	endtask

	// Random traffic over several settings with different idling on each side.
	task automatic test_random_traffic();
		int ph;
		for (ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_config(SS_THRESH_RST, PKT_LEN_RST, MIN_PKTS_RST, MAX_PKTS_RST);
				1: set_config(32'd30000, PKT_LEN_RST, MIN_PKTS_RST, MAX_PKTS_RST);
				2: set_config('0, 16'd1460, 16'd4, 16'd100);
				3: set_config($urandom_range(0, 3), 16'd1, 16'd1, 16'd1);
				4: set_config(WORD_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				5: set_config(32'd100000, 16'd9000, 16'd500, 16'd10);
				default: set_config($urandom(), 16'($urandom_range(1, 16'hFFFF)),
					16'($urandom_range(1, 64)), 16'($urandom_range(1, 16'hFFFF)));
			endcase
			tx_idle_en = (ph % 3 != 1);
			rx_idle_en = (ph % 3 != 1);
			if (ph % 3 == 2)
				tx_idle_en = 1'b0;
			run_traffic(PHASE_EVENTS);
		end
		wait_idle();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Main sequence: one reset, then each test in turn, then the verdict.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_defaults();
		test_config_extremes();
		test_backpressure();
		test_sender_pause();
		test_random_traffic();
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (window_results_q.size() != 0) begin
			fail_count += window_results_q.size();
			$display("ERROR: %0d results never arrived", window_results_q.size());
		end
		$display("Summary: %0d events accepted, %0d results checked, %0d mismatches",
			n_accepted, n_checked, fail_count);
		$display("Covered %0d register settings, long output hold-off, sender pauses",
			n_settings);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: several times the slowest correct run.
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- reno_window_update_top.f -----
src/reno_pkg.sv
src/reno_div.sv
src/reno_back.sv
src/reno_front.sv
src/reno_window_update_top.sv
dv/reno_window_update_top_tb.sv
